// File: sv/marked_message_fifo_assert.svh
// Assertion macros for the marked message queue.
// Used at the end of the top level; expects clk and rst_n in scope.
`ifndef MARKED_MESSAGE_FIFO_ASSERT_SVH
`define MARKED_MESSAGE_FIFO_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MMF_ASSERT_IMPL(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("marked_message_fifo: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MMF_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("marked_message_fifo: next-cycle check failed");

`endif

// File: sv/mmf_pkg.sv
// Shared types and field widths for the marked message queue.
// No dependencies.
package mmf_pkg;

    localparam int VALUE_W = 32;
    localparam int ACTION_W = 3;
    localparam int COUNT_W = 7;
    localparam int SUM_W = 38;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_AGE    = 3'd2,
        ACT_MARK   = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_STATUS = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               mark;
    } entry_t;

endpackage

// File: sv/mmf_cell.sv
// One storage cell of the queue ring: holds a value and its end mark.
// Depends on mmf_pkg for the entry type.
module mmf_cell (
    input  logic            clk,
    input  logic            shift,
    input  mmf_pkg::entry_t d_in,
    output mmf_pkg::entry_t q
);
    import mmf_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// File: sv/mmf_ctrl.sv
// Sequencer of the marked message queue: takes actions, runs the ring scan,
// updates the head cell on its way to the tail and accumulates status.
// Depends on mmf_pkg.
module mmf_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mmf_pkg::ACTION_W-1:0] action,
    input  logic [mmf_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mmf_pkg::VALUE_W-1:0]  popped_value,
    output logic                         popped_last,
    output logic                         refused,
    output logic [mmf_pkg::COUNT_W-1:0]  entry_count,
    output logic [mmf_pkg::COUNT_W-1:0]  message_size,
    output logic [mmf_pkg::SUM_W-1:0]    total_sum,
    input  mmf_pkg::entry_t              head,
    output mmf_pkg::entry_t              feed,
    output logic                         shift
);
    import mmf_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    action_t              act_reg, act_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [VALUE_W-1:0]   pop_val_reg, pop_val_next;
    logic                 pop_last_reg, pop_last_next;
    logic                 refused_reg, refused_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     msize_reg, msize_next;
    logic                 found_reg, found_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_pval_reg, out_pval_next;
    logic                 out_plast_reg, out_plast_next;
    logic                 out_ref_reg, out_ref_next;
    logic [CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic [CNT_W-1:0]     out_msize_reg, out_msize_next;
    logic [SUM_W-1:0]     out_sum_reg, out_sum_next;

    logic [CNT_W-1:0]     k_ext;
    logic                 in_range;
    logic                 take;
    entry_t               ent;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        pop_val_next   = pop_val_reg;
        pop_last_next  = pop_last_reg;
        refused_next   = refused_reg;
        sum_next       = sum_reg;
        msize_next     = msize_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_pval_next  = out_pval_reg;
        out_plast_next = out_plast_reg;
        out_ref_next   = out_ref_reg;
        out_cnt_next   = out_cnt_reg;
        out_msize_next = out_msize_reg;
        out_sum_next   = out_sum_reg;
        shift          = 1'b0;
        feed           = head;
        ent            = head;
        take           = 1'b0;
        k_ext          = CNT_W'(k_reg);
        in_range       = (k_ext < count_reg);

        // drop the result once the far side takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next      = action_t'(action);
                    val_next      = value;
                    k_next        = '0;
                    sum_next      = '0;
                    msize_next    = '0;
                    found_next    = 1'b0;
                    pop_val_next  = '0;
                    pop_last_next = 1'b0;
                    refused_next  = 1'b0;
                    state_next    = ST_SCAN;
                    case (action_t'(action))
                        ACT_PUSH:
                        begin
                            refused_next = (count_reg == FULL_CNT);
                        end
                        ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                refused_next = 1'b1;
                            end
                            else
                            begin
                                // rotate the head out; it lands past the new tail
                                pop_val_next  = head.value;
                                pop_last_next = head.mark;
                                count_next    = count_reg - CNT_W'(1);
                                shift         = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                shift = 1'b1;
                take  = in_range;
                if (act_reg == ACT_AGE && in_range && ent.value != '1)
                begin
                    ent.value = head.value + VALUE_W'(1);
                end
                if (act_reg == ACT_MARK && (k_ext + CNT_W'(1)) == count_reg)
                begin
                    ent.mark = 1'b1;
                end
                if (act_reg == ACT_PUSH && !refused_reg && k_ext == count_reg)
                begin
                    ent.value = val_reg;
                    ent.mark  = 1'b0;
                    take      = 1'b1;
                end
                feed = ent;
                if (take)
                begin
                    sum_next = sum_reg + SUM_W'(ent.value);
                    if (ent.mark && !found_reg)
                    begin
                        found_next = 1'b1;
                        msize_next = k_ext + CNT_W'(1);
                    end
                end
                k_next = k_reg + IDX_W'(1);
                if (k_reg == LAST_IDX)
                begin
                    k_next     = '0;
                    state_next = ST_DONE;
                    if (act_reg == ACT_PUSH && !refused_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end

            ST_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_pval_next  = pop_val_reg;
                    out_plast_next = pop_last_reg;
                    out_ref_next   = refused_reg;
                    out_cnt_next   = count_reg;
                    out_msize_next = found_reg ? msize_reg : count_reg;
                    out_sum_next   = sum_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        val_reg       <= val_next;
        pop_val_reg   <= pop_val_next;
        pop_last_reg  <= pop_last_next;
        refused_reg   <= refused_next;
        sum_reg       <= sum_next;
        msize_reg     <= msize_next;
        found_reg     <= found_next;
        out_pval_reg  <= out_pval_next;
        out_plast_reg <= out_plast_next;
        out_ref_reg   <= out_ref_next;
        out_cnt_reg   <= out_cnt_next;
        out_msize_reg <= out_msize_next;
        out_sum_reg   <= out_sum_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign popped_value = out_pval_reg;
    assign popped_last  = out_plast_reg;
    assign refused      = out_ref_reg;
    assign entry_count  = COUNT_W'(out_cnt_reg);
    assign message_size = COUNT_W'(out_msize_reg);
    assign total_sum    = out_sum_reg;

endmodule

// File: sv/marked_message_fifo.sv
// Top level of the marked message queue: a ring of storage cells and the
// sequencer that scans it. Depends on mmf_pkg, mmf_cell, mmf_ctrl and
// marked_message_fifo_assert.svh.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  in       | in_valid / in_stall   | action, value
//  out      | out_valid / out_stall | popped_value, popped_last, refused,
//           |                       | entry_count, message_size, total_sum
//
// Each action runs in order: the transfer, a scan in which the ring turns once
// past the head cell (aging, marking, pushing and summing one entry per cycle),
// and the load of the result register.
// Reset empties the queue; cell contents are not cleared.
// A stalled result is held; the next action is taken once the result register
// is loaded, and a finished action holds in its last cycle, stalling the input,
// until the result that still waits is taken.
module marked_message_fifo #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mmf_pkg::ACTION_W-1:0] action,
    input  logic [mmf_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mmf_pkg::VALUE_W-1:0]  popped_value,
    output logic                         popped_last,
    output logic                         refused,
    output logic [mmf_pkg::COUNT_W-1:0]  entry_count,
    output logic [mmf_pkg::COUNT_W-1:0]  message_size,
    output logic [mmf_pkg::SUM_W-1:0]    total_sum
);
    import mmf_pkg::*;

    entry_t cell_q [DEPTH];
    entry_t feed;
    logic   shift;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t d_in;
            if (i == DEPTH - 1)
            begin : g_tail
                assign d_in = feed;
            end
            else
            begin : g_body
                assign d_in = cell_q[i+1];
            end
            mmf_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d_in  (d_in),
                .q     (cell_q[i])
            );
        end
    endgenerate

    mmf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .popped_last  (popped_last),
        .refused      (refused),
        .entry_count  (entry_count),
        .message_size (message_size),
        .total_sum    (total_sum),
        .head         (cell_q[0]),
        .feed         (feed),
        .shift        (shift)
    );

    `include "marked_message_fifo_assert.svh"

    `MMF_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
    `MMF_ASSERT_IMPL(a_refused_no_pop, out_valid && refused, popped_value == '0 && !popped_last)
    `MMF_ASSERT_IMPL(a_no_shift_idle, !in_stall && !in_valid, !shift)

endmodule

// File: bench/testbench.sv
// Self-checking bench for marked_message_fifo: random bursts of queue actions go in,
// and every result is compared with an in-bench model of the queue.
// Depends on mmf_pkg and the marked_message_fifo RTL.
module testbench;
    import mmf_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int TARGET_ITEMS = 850;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 3 * (QUEUE_DEPTH + 2);
    localparam int HOLD_OFF_CYCLES = 1200;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  val;
    } queue_op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] popped_value;
        logic               popped_last;
        logic               refused;
        logic [COUNT_W-1:0] entry_count;
        logic [COUNT_W-1:0] message_size;
        logic [SUM_W-1:0]   total_sum;
    } queue_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = ACT_STATUS;
    logic [VALUE_W-1:0]  value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VALUE_W-1:0]  popped_value;
    logic                popped_last;
    logic                refused;
    logic [COUNT_W-1:0]  entry_count;
    logic [COUNT_W-1:0]  message_size;
    logic [SUM_W-1:0]    total_sum;

    queue_op_t     pending_items[$];
    queue_result_t expected_results[$];
    logic [VALUE_W-1:0] held_values[$];
    logic               held_marks[$];

    int est_fill = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    int stall_mode = 0;

    marked_message_fifo #(.DEPTH(QUEUE_DEPTH)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .popped_value(popped_value),
        .popped_last(popped_last),
        .refused(refused),
        .entry_count(entry_count),
        .message_size(message_size),
        .total_sum(total_sum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one action to the modeled queue and return the result it should give.
    function automatic queue_result_t apply_action(input logic [ACTION_W-1:0] act,
                                                   input logic [VALUE_W-1:0] val);
        queue_result_t r;
        logic [SUM_W-1:0] sum;
        int n;
        r = '0;
        case (act)
            ACT_PUSH:
                if (held_values.size() < QUEUE_DEPTH)
                begin
                    held_values.push_back(val);
                    held_marks.push_back(1'b0);
                end
                else
                    r.refused = 1'b1;
            ACT_POP:
                if (held_values.size() > 0)
                begin
                    r.popped_value = held_values.pop_front();
                    r.popped_last = held_marks.pop_front();
                end
                else
                    r.refused = 1'b1;
            ACT_AGE:
                foreach (held_values[i])
                    if (held_values[i] != '1)
                        held_values[i] = held_values[i] + 1'b1;
            ACT_MARK:
                if (held_marks.size() > 0)
                    held_marks[held_marks.size() - 1] = 1'b1;
            ACT_CLEAR:
            begin
                held_values.delete();
                held_marks.delete();
            end
            default: ;
        endcase
        n = held_values.size();
        r.entry_count = COUNT_W'(n);
        r.message_size = COUNT_W'(n);
        // walk down so the first mark from the head wins
        for (int i = n - 1; i >= 0; i--)
            if (held_marks[i])
                r.message_size = COUNT_W'(i + 1);
        sum = '0;
        foreach (held_values[i])
            sum = sum + {{(SUM_W - VALUE_W){1'b0}}, held_values[i]};
        r.total_sum = sum;
        return r;
    endfunction

    task automatic add_op(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
        queue_op_t op;
        op.act = act;
        op.val = val;
        pending_items.push_back(op);
        case (act)
            ACT_PUSH: if (est_fill < QUEUE_DEPTH) est_fill++;
            ACT_POP: if (est_fill > 0) est_fill--;
            ACT_CLEAR: est_fill = 0;
            default: ;
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return VALUE_W'($urandom_range(0, 15));
            1: return '1 - VALUE_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7) return ACT_PUSH;
        if (r < 12) return ACT_POP;
        if (r < 14) return ACT_AGE;
        if (r < 16) return ACT_MARK;
        if (r == 16) return ACT_CLEAR;
        if (r == 17) return ACT_STATUS;
        if (r == 18) return ACT_SPARE_LO;
        return ACT_SPARE_HI;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        $display("result %0d: %s got %0h, expected %0h", results_checked, what, seen, wanted);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] seen,
                               input logic [63:0] wanted);
        if (seen !== wanted)
            report_mismatch(what, seen, wanted);
    endtask

    // Sender: bursts of transfers with random gaps; hold the payload while stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_action(action, value));
                void'(pending_items.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_valid <= 1'b1;
                    action <= pending_items[0].act;
                    value <= pending_items[0].val;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern is re-picked periodically; twice hold off long
    // enough that the queue backs up into the input.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            rx_cycle++;
            if (rx_cycle % 300 == 0)
                stall_mode = $urandom_range(0, 3);
            if (rx_cycle == 2000 || rx_cycle == 20000)
                hold_left = HOLD_OFF_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= rx_cycle[2];
                endcase
        end
    end

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", {popped_value, 32'h0}, 64'h0);
            else
            begin
                want = expected_results.pop_front();
                check_field("popped_value", popped_value, want.popped_value);
                check_field("popped_last", popped_last, want.popped_last);
                check_field("refused", refused, want.refused);
                check_field("entry_count", entry_count, want.entry_count);
                check_field("message_size", message_size, want.message_size);
                check_field("total_sum", total_sum, want.total_sum);
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        // Directed: empty-queue corners, value extremes, saturation, marks, spare codes.
        add_op(ACT_STATUS, '0);
        add_op(ACT_POP, '1);
        add_op(ACT_MARK, '0);
        add_op(ACT_AGE, '0);
        add_op(ACT_CLEAR, '0);
        add_op(ACT_PUSH, '0);
        add_op(ACT_PUSH, '1);
        add_op(ACT_PUSH, 32'hFFFF_FFFE);
        add_op(ACT_AGE, '0);
        add_op(ACT_MARK, '0);
        add_op(ACT_PUSH, 32'h0000_0001);
        add_op(ACT_SPARE_LO, '1);
        add_op(ACT_SPARE_HI, '0);
        add_op(ACT_MARK, '0);
        add_op(ACT_POP, '0);
        add_op(ACT_POP, '0);
        add_op(ACT_POP, '0);
        add_op(ACT_PUSH, 32'hA5A5_5A5A);
        add_op(ACT_CLEAR, '0);
        add_op(ACT_POP, '0);
        add_op(ACT_PUSH, 32'h5A5A_A5A5);
        add_op(ACT_POP, '0);

        // Random: fill and drain runs shaped as messages, mixed with loose actions.
        while (pending_items.size() < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    repeat ($urandom_range(8, 30))
                        add_op(pick_action(), pick_value());
                4, 5:
                begin
                    while (est_fill < QUEUE_DEPTH)
                    begin
                        add_op(ACT_PUSH, pick_value());
                        if ($urandom_range(0, 7) == 0)
                            add_op(ACT_MARK, $urandom);
                    end
                    repeat ($urandom_range(1, 3))
                        add_op(ACT_PUSH, pick_value());
                end
                6, 7:
                    repeat ($urandom_range(1, est_fill + 2))
                        add_op(ACT_POP, $urandom);
                8:
                    repeat ($urandom_range(1, 4))
                    begin
                        add_op(ACT_AGE, $urandom);
                        add_op(ACT_STATUS, $urandom);
                    end
                default:
                    add_op(ACT_CLEAR, $urandom);
            endcase
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
